>>> design/pps_pkg.sv
// Package for the preemptive priority scheduler: field widths, command codes,
// register addresses, stream widths and the sequencer state type.
// No dependencies.
package pps_pkg;

    localparam int PRIO_BITS    = 8;
    localparam int ID_W         = 4;
    localparam int FIELD_TIME_W = 16;
    localparam int COUNT_W      = 5;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 48;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 72;
    localparam int LEFT_W       = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_COUNT = 3'd0;
    localparam logic [COUNT_W-1:0]    PROCESS_COUNT_RESET = 5'd1;

    localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_MANY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

endpackage

>>> design/pps_cell.sv
// One process slot of the scheduler chain: holds an entry and merges it into
// the candidate passed along from the previous slot. Depends on pps_pkg.
module pps_cell #(
    parameter int TIME_BITS = 16,
    parameter int IDX_BITS  = 4,
    parameter int MY_INDEX  = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          counted,
    input  logic [TIME_BITS-1:0]          cur_time,
    input  logic                          ld_en,
    input  logic [pps_pkg::PRIO_BITS-1:0] ld_prio,
    input  logic [TIME_BITS-1:0]          ld_arr,
    input  logic [TIME_BITS-1:0]          ld_burst,
    input  logic                          cm_en,
    input  logic [TIME_BITS-1:0]          cm_rem,
    input  logic                          cm_done,
    input  logic                          tin_found,
    input  logic [IDX_BITS-1:0]           tin_idx,
    input  logic [pps_pkg::PRIO_BITS-1:0] tin_prio,
    input  logic [TIME_BITS-1:0]          tin_arr,
    input  logic [TIME_BITS-1:0]          tin_burst,
    input  logic [TIME_BITS-1:0]          tin_rem,
    input  logic                          tin_started,
    input  logic [pps_pkg::LEFT_W-1:0]    tin_left,
    output logic                          tout_found,
    output logic [IDX_BITS-1:0]           tout_idx,
    output logic [pps_pkg::PRIO_BITS-1:0] tout_prio,
    output logic [TIME_BITS-1:0]          tout_arr,
    output logic [TIME_BITS-1:0]          tout_burst,
    output logic [TIME_BITS-1:0]          tout_rem,
    output logic                          tout_started,
    output logic [pps_pkg::LEFT_W-1:0]    tout_left
);
    import pps_pkg::*;

    logic [PRIO_BITS-1:0] prio_reg;
    logic [TIME_BITS-1:0] arr_reg;
    logic [TIME_BITS-1:0] burst_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic                 started_reg;
    logic                 done_reg;

    logic                 elig;
    logic                 take;
    logic                 pending;
    logic [LEFT_W-1:0]    left_next;

    always_ff @(posedge aclk) begin
        if (ld_en) begin
            prio_reg  <= ld_prio;
            arr_reg   <= ld_arr;
            burst_reg <= ld_burst;
            rem_reg   <= ld_burst;
        end else if (cm_en) begin
            rem_reg <= cm_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else if (ld_en) begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else if (cm_en) begin
            started_reg <= 1'b1;
            done_reg    <= cm_done;
        end
    end

    assign pending = counted && !done_reg;
    assign elig    = pending && (arr_reg <= cur_time);
    assign take    = elig && (!tin_found || (prio_reg > tin_prio));

    always_comb begin
        if (tin_left == LEFT_MANY) begin
            left_next = LEFT_MANY;
        end else if (pending) begin
            left_next = tin_left + LEFT_ONE;
        end else begin
            left_next = tin_left;
        end
    end

    always_ff @(posedge aclk) begin
        tout_found <= tin_found || elig;
        tout_left  <= left_next;
        if (take) begin
            tout_idx     <= IDX_BITS'(MY_INDEX);
            tout_prio    <= prio_reg;
            tout_arr     <= arr_reg;
            tout_burst   <= burst_reg;
            tout_rem     <= rem_reg;
            tout_started <= started_reg;
        end else begin
            tout_idx     <= tin_idx;
            tout_prio    <= tin_prio;
            tout_arr     <= tin_arr;
            tout_burst   <= tin_burst;
            tout_rem     <= tin_rem;
            tout_started <= tin_started;
        end
    end

endmodule

>>> design/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler top level: stream ports, APB register, sequencer and
// a chain of pps_cell slots. Depends on pps_pkg and pps_cell.
// A load item is written into its slot as it is accepted. A tick item walks the candidate
// along the cell chain one slot per cycle in ST_SWEEP, then commits in ST_COMMIT, which
// waits for the output to be free; the result is registered onto m_tdata at the commit.
// Synchronous active-low reset clears time, slot flags and the register to count 1.
module preemptive_priority_scheduler_core #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index, priority_req, arrival, burst, then zero fill
    input  logic [pps_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [pps_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ran, running_id, first_run, response, finished, completion_time,
    // turnaround, waiting, all_done
    output logic [pps_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pps_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pps_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_PROCS);
    localparam int CNT_BITS = $clog2(MAX_PROCS);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [COUNT_W-1:0]   process_count_reg, process_count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 in_fire;
    logic                 cmd;
    logic [ID_W-1:0]      in_idx;
    logic [PRIO_BITS-1:0] in_prio;
    logic [TIME_BITS+FIELD_TIME_W-1:0] in_arr_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] in_burst_ext;
    logic [TIME_BITS-1:0] in_arr;
    logic [TIME_BITS-1:0] in_burst;
    logic                 load_fire;
    logic                 cfg_write;
    logic                 commit_fire;

    logic                 tk_found   [MAX_PROCS];
    logic [IDX_BITS-1:0]  tk_idx     [MAX_PROCS];
    logic [PRIO_BITS-1:0] tk_prio    [MAX_PROCS];
    logic [TIME_BITS-1:0] tk_arr     [MAX_PROCS];
    logic [TIME_BITS-1:0] tk_burst   [MAX_PROCS];
    logic [TIME_BITS-1:0] tk_rem     [MAX_PROCS];
    logic                 tk_started [MAX_PROCS];
    logic [LEFT_W-1:0]    tk_left    [MAX_PROCS];
    logic [MAX_PROCS-1:0] counted;

    logic                 best_found;
    logic [IDX_BITS-1:0]  best_idx;
    logic [TIME_BITS-1:0] best_arr;
    logic [TIME_BITS-1:0] best_burst;
    logic [TIME_BITS-1:0] best_rem;
    logic                 best_started;
    logic [LEFT_W-1:0]    best_left;

    logic                 first_run;
    logic                 fin;
    logic                 all_done;
    logic [TIME_BITS-1:0] resp_t;
    logic [TIME_BITS-1:0] ct_t;
    logic [TIME_BITS-1:0] tat_t;
    logic [TIME_BITS-1:0] wt_t;
    logic [TIME_BITS-1:0] cm_rem;
    logic [IDX_BITS+ID_W-1:0]          id_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] resp_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] ct_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] tat_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] wt_ext;

    // Input unpacking.
    assign cmd          = s_tuser[0];
    assign in_idx       = s_tdata[3:0];
    assign in_prio      = s_tdata[11:4];
    assign in_arr_ext   = {{TIME_BITS{1'b0}}, s_tdata[27:12]};
    assign in_burst_ext = {{TIME_BITS{1'b0}}, s_tdata[43:28]};
    assign in_arr       = in_arr_ext[TIME_BITS-1:0];
    assign in_burst     = in_burst_ext[TIME_BITS-1:0];

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign load_fire   = in_fire && (cmd == CMD_LOAD) && (int'(in_idx) < MAX_PROCS);
    assign commit_fire = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        process_count_next = process_count_reg;
        if (cfg_write && (paddr == REG_PROCESS_COUNT)) begin
            process_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == REG_PROCESS_COUNT) begin
            prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, process_count_reg};
        end else begin
            prdata = '0;
        end
    end

    // Cell chain.
    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            logic                 c_ld_en;
            logic                 c_cm_en;
            logic                 p_found;
            logic [IDX_BITS-1:0]  p_idx;
            logic [PRIO_BITS-1:0] p_prio;
            logic [TIME_BITS-1:0] p_arr;
            logic [TIME_BITS-1:0] p_burst;
            logic [TIME_BITS-1:0] p_rem;
            logic                 p_started;
            logic [LEFT_W-1:0]    p_left;

            assign counted[g] = (int'(process_count_reg) > g);
            assign c_ld_en    = load_fire && (int'(in_idx) == g);
            assign c_cm_en    = commit_fire && best_found && (int'(best_idx) == g);

            if (g == 0) begin : g_head
                assign p_found   = 1'b0;
                assign p_idx     = '0;
                assign p_prio    = '0;
                assign p_arr     = '0;
                assign p_burst   = '0;
                assign p_rem     = '0;
                assign p_started = 1'b0;
                assign p_left    = LEFT_NONE;
            end else begin : g_link
                assign p_found   = tk_found[g-1];
                assign p_idx     = tk_idx[g-1];
                assign p_prio    = tk_prio[g-1];
                assign p_arr     = tk_arr[g-1];
                assign p_burst   = tk_burst[g-1];
                assign p_rem     = tk_rem[g-1];
                assign p_started = tk_started[g-1];
                assign p_left    = tk_left[g-1];
            end

            pps_cell #(
                .TIME_BITS (TIME_BITS),
                .IDX_BITS  (IDX_BITS),
                .MY_INDEX  (g)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .counted      (counted[g]),
                .cur_time     (time_reg),
                .ld_en        (c_ld_en),
                .ld_prio      (in_prio),
                .ld_arr       (in_arr),
                .ld_burst     (in_burst),
                .cm_en        (c_cm_en),
                .cm_rem       (cm_rem),
                .cm_done      (fin),
                .tin_found    (p_found),
                .tin_idx      (p_idx),
                .tin_prio     (p_prio),
                .tin_arr      (p_arr),
                .tin_burst    (p_burst),
                .tin_rem      (p_rem),
                .tin_started  (p_started),
                .tin_left     (p_left),
                .tout_found   (tk_found[g]),
                .tout_idx     (tk_idx[g]),
                .tout_prio    (tk_prio[g]),
                .tout_arr     (tk_arr[g]),
                .tout_burst   (tk_burst[g]),
                .tout_rem     (tk_rem[g]),
                .tout_started (tk_started[g]),
                .tout_left    (tk_left[g])
            );
        end
    endgenerate

    assign best_found   = tk_found[MAX_PROCS-1];
    assign best_idx     = tk_idx[MAX_PROCS-1];
    assign best_arr     = tk_arr[MAX_PROCS-1];
    assign best_burst   = tk_burst[MAX_PROCS-1];
    assign best_rem     = tk_rem[MAX_PROCS-1];
    assign best_started = tk_started[MAX_PROCS-1];
    assign best_left    = tk_left[MAX_PROCS-1];

    // Result of the tick for the chosen entry.
    always_comb begin
        first_run = best_found && !best_started;
        fin       = best_found && (best_rem <= TIME_BITS'(1));
        resp_t    = time_reg - best_arr;
        ct_t      = (time_reg < TIME_MAX) ? time_reg + TIME_BITS'(1) : TIME_MAX;
        tat_t     = ct_t - best_arr;
        wt_t      = (tat_t > best_burst) ? tat_t - best_burst : '0;
        cm_rem    = fin ? '0 : best_rem - TIME_BITS'(1);
        all_done  = (best_left == LEFT_NONE) || ((best_left == LEFT_ONE) && fin);
        id_ext    = {{ID_W{1'b0}}, best_idx};
        resp_ext  = {{FIELD_TIME_W{1'b0}}, resp_t};
        ct_ext    = {{FIELD_TIME_W{1'b0}}, ct_t};
        tat_ext   = {{FIELD_TIME_W{1'b0}}, tat_t};
        wt_ext    = {{FIELD_TIME_W{1'b0}}, wt_t};
        m_tdata_next        = '0;
        m_tdata_next[71]    = all_done;
        if (best_found) begin
            m_tdata_next[0]   = 1'b1;
            m_tdata_next[4:1] = id_ext[ID_W-1:0];
        end
        if (first_run) begin
            m_tdata_next[5]    = 1'b1;
            m_tdata_next[21:6] = resp_ext[FIELD_TIME_W-1:0];
        end
        if (fin) begin
            m_tdata_next[22]    = 1'b1;
            m_tdata_next[38:23] = ct_ext[FIELD_TIME_W-1:0];
            m_tdata_next[54:39] = tat_ext[FIELD_TIME_W-1:0];
            m_tdata_next[70:55] = wt_ext[FIELD_TIME_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        time_next      = time_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (cmd == CMD_TICK)) begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                end
            end
            ST_SWEEP: begin
                if (sweep_cnt_reg == CNT_BITS'(MAX_PROCS - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + CNT_BITS'(1);
                end
            end
            ST_COMMIT: begin
                if (commit_fire) begin
                    state_next = ST_IDLE;
                    time_next  = (time_reg < TIME_MAX) ? time_reg + TIME_BITS'(1) : TIME_MAX;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (commit_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            sweep_cnt_reg     <= '0;
            time_reg          <= '0;
            process_count_reg <= PROCESS_COUNT_RESET;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            sweep_cnt_reg     <= sweep_cnt_next;
            time_reg          <= time_next;
            process_count_reg <= process_count_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
